// File: sv/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg: shared types and constants of the video service block
// Service codes, mode numbers, status codes, the decoded command that passes
// from the front end to the execution unit, and the back end state encoding.
// ----------------------------------------------------------------------------
package bvs_pkg;

  // Default screen geometry, handed to the top level parameters.
  localparam int DEF_TEXT_COLUMNS = 80;
  localparam int DEF_TEXT_ROWS    = 25;
  localparam int DEF_GFX_WIDTH    = 320;
  localparam int DEF_GFX_HEIGHT   = 200;

  // Widest pixel address over the supported geometry range (1024 x 768).
  localparam int PIX_ADDR_MAX_W = 20;

  // Command queue depth. It must be a power of two so the pointers wrap.
  localparam int CMDQ_DEPTH = 2;

  // Service codes carried in AH.
  localparam logic [7:0] FN_SET_MODE        = 8'h00;
  localparam logic [7:0] FN_SET_CURSOR      = 8'h02;
  localparam logic [7:0] FN_GET_CURSOR      = 8'h03;
  localparam logic [7:0] FN_WRITE_CHAR_ATTR = 8'h09;
  localparam logic [7:0] FN_WRITE_CHAR      = 8'h0A;
  localparam logic [7:0] FN_WRITE_PIXEL     = 8'h0C;
  localparam logic [7:0] FN_READ_PIXEL      = 8'h0D;
  localparam logic [7:0] FN_TELETYPE        = 8'h0E;
  localparam logic [7:0] FN_GET_MODE        = 8'h0F;

  // Supported video modes.
  localparam logic [7:0] MODE_TEXT = 8'h03;
  localparam logic [7:0] MODE_GFX  = 8'h13;

  // Cursor shape returned by get cursor, and the mask that clears BH.
  localparam logic [15:0] CURSOR_SHAPE  = 16'h0607;
  localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNSUP = 2'd1,
    STAT_FAULT = 2'd2,
    STAT_TTY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_SET_MODE,
    OP_SET_CURSOR,
    OP_GET_CURSOR,
    OP_WRITE_CHAR,
    OP_WRITE_PIXEL,
    OP_READ_PIXEL,
    OP_TELETYPE,
    OP_GET_MODE,
    OP_UNSUPPORTED
  } op_t;

  typedef struct packed {
    logic [7:0]  function_req;
    logic [7:0]  al;
    logic [15:0] bx;
    logic [15:0] cx;
    logic [15:0] dx;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_ax;
    logic [15:0] out_bx;
    logic [15:0] out_cx;
    logic [15:0] out_dx;
  } out_item_t;

  // Decoded call as queued between the front end and the execution unit.
  typedef struct packed {
    op_t                       op;
    logic                      wr_attr;
    logic                      pix_ok;
    logic [PIX_ADDR_MAX_W-1:0] pix_addr;
    in_item_t                  item;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_FINISH
  } back_state_t;

endpackage

// File: sv/bvs_front.sv
// ----------------------------------------------------------------------------
// bvs_front: call decoder
// Takes one transaction per cycle unless held off by a full queue, classifies
// the service code, checks pixel bounds, forms the pixel address and queues it.
// ----------------------------------------------------------------------------
module bvs_front #(
  parameter int GFX_WIDTH  = bvs_pkg::DEF_GFX_WIDTH,
  parameter int GFX_HEIGHT = bvs_pkg::DEF_GFX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bvs_pkg::in_item_t in_data,
  output logic              q_push,
  input  logic              q_full,
  output bvs_pkg::cmd_t     q_data
);

  localparam int PIX_COUNT = GFX_WIDTH * GFX_HEIGHT;
  localparam int PIX_AW    = $clog2(PIX_COUNT);
  localparam logic [PIX_AW-1:0] GW = PIX_AW'(GFX_WIDTH);

  logic                  fr_valid_r, fr_valid_nxt;
  bvs_pkg::cmd_t         fr_cmd_r, fr_cmd_nxt;
  logic                  accept;
  logic [PIX_AW-1:0]     pix_addr;

  // Hold off the source only while a decoded command waits on a full queue.
  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = fr_valid_r && !q_full;
  assign q_data   = fr_cmd_r;

  // Row-major pixel address; only meaningful when the bounds check passes.
  assign pix_addr = PIX_AW'(in_data.dx) * GW + PIX_AW'(in_data.cx);

  // Classify the call.
  always_comb begin
    fr_cmd_nxt          = fr_cmd_r;
    fr_valid_nxt        = fr_valid_r && !q_push;
    if (accept) begin
      fr_valid_nxt        = 1'b1;
      fr_cmd_nxt.item     = in_data;
      fr_cmd_nxt.wr_attr  = 1'b0;
      fr_cmd_nxt.pix_ok   = (in_data.cx < 16'(GFX_WIDTH)) && (in_data.dx < 16'(GFX_HEIGHT));
      fr_cmd_nxt.pix_addr = bvs_pkg::PIX_ADDR_MAX_W'(pix_addr);
      unique case (in_data.function_req)
        bvs_pkg::FN_SET_MODE: begin
          if (in_data.al == bvs_pkg::MODE_TEXT || in_data.al == bvs_pkg::MODE_GFX) begin
            fr_cmd_nxt.op = bvs_pkg::OP_SET_MODE;
          end else begin
            fr_cmd_nxt.op = bvs_pkg::OP_UNSUPPORTED;
          end
        end
        bvs_pkg::FN_SET_CURSOR:  fr_cmd_nxt.op = bvs_pkg::OP_SET_CURSOR;
        bvs_pkg::FN_GET_CURSOR:  fr_cmd_nxt.op = bvs_pkg::OP_GET_CURSOR;
        bvs_pkg::FN_WRITE_CHAR_ATTR: begin
          fr_cmd_nxt.op      = bvs_pkg::OP_WRITE_CHAR;
          fr_cmd_nxt.wr_attr = 1'b1;
        end
        bvs_pkg::FN_WRITE_CHAR:  fr_cmd_nxt.op = bvs_pkg::OP_WRITE_CHAR;
        bvs_pkg::FN_WRITE_PIXEL: fr_cmd_nxt.op = bvs_pkg::OP_WRITE_PIXEL;
        bvs_pkg::FN_READ_PIXEL:  fr_cmd_nxt.op = bvs_pkg::OP_READ_PIXEL;
        bvs_pkg::FN_TELETYPE:    fr_cmd_nxt.op = bvs_pkg::OP_TELETYPE;
        bvs_pkg::FN_GET_MODE:    fr_cmd_nxt.op = bvs_pkg::OP_GET_MODE;
        default:                 fr_cmd_nxt.op = bvs_pkg::OP_UNSUPPORTED;
      endcase
    end
  end

  // Decode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_cmd_r <= fr_cmd_nxt;
  end

endmodule

// File: sv/bvs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bvs_cmd_fifo: command queue
// A short first-in first-out queue of decoded commands that lets the decoder
// and the execution unit stall independently.
// ----------------------------------------------------------------------------
module bvs_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bvs_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output bvs_pkg::cmd_t pop_data
);

  localparam int PW = (bvs_pkg::CMDQ_DEPTH > 1) ? $clog2(bvs_pkg::CMDQ_DEPTH) : 1;

  bvs_pkg::cmd_t entry_r [bvs_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == (PW + 1)'(bvs_pkg::CMDQ_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/bvs_back.sv
// ----------------------------------------------------------------------------
// bvs_back: execution unit
// Holds the video mode, the cursor, the text cell memories and the pixel
// memory. Runs one command at a time and loads the result register.
// ----------------------------------------------------------------------------
module bvs_back #(
  parameter int TEXT_COLUMNS = bvs_pkg::DEF_TEXT_COLUMNS,
  parameter int TEXT_ROWS    = bvs_pkg::DEF_TEXT_ROWS,
  parameter int GFX_WIDTH    = bvs_pkg::DEF_GFX_WIDTH,
  parameter int GFX_HEIGHT   = bvs_pkg::DEF_GFX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  bvs_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bvs_pkg::out_item_t out_data
);

  localparam int CELL_COUNT = TEXT_ROWS * TEXT_COLUMNS;
  localparam int PIX_COUNT  = GFX_WIDTH * GFX_HEIGHT;
  localparam int CLR_COUNT  = (CELL_COUNT > PIX_COUNT) ? CELL_COUNT : PIX_COUNT;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int PIX_AW     = $clog2(PIX_COUNT);
  localparam int CLR_W      = $clog2(CLR_COUNT + 1);

  localparam logic [CELL_AW-1:0] CELL_LAST  = CELL_AW'(CELL_COUNT - 1);
  localparam logic [CELL_AW-1:0] COLS_W     = CELL_AW'(TEXT_COLUMNS);
  localparam logic [CLR_W-1:0]   CLR_LAST   = CLR_W'(CLR_COUNT - 1);
  localparam logic [CLR_W-1:0]   CELL_END   = CLR_W'(CELL_COUNT);
  localparam logic [CLR_W-1:0]   PIX_END    = CLR_W'(PIX_COUNT);
  localparam logic [7:0]         ROW_MAX    = 8'(TEXT_ROWS - 1);
  localparam logic [7:0]         COL_MAX    = 8'(TEXT_COLUMNS - 1);
  localparam logic [7:0]         TEXT_COLS_B = 8'(TEXT_COLUMNS);
  localparam logic [7:0]         GFX_COLS_B  = 8'(GFX_WIDTH / 8);

  // Memories.
  logic [7:0] char_mem [CELL_COUNT];
  logic [7:0] attr_mem [CELL_COUNT];
  logic [7:0] pix_mem  [PIX_COUNT];

  // Control and architectural state.
  bvs_pkg::back_state_t state_r, state_nxt;
  logic [7:0]           mode_r, mode_nxt;
  logic [7:0]           row_r, row_nxt;
  logic [7:0]           col_r, col_nxt;
  logic [CLR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic                 clr_resp_r, clr_resp_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Payload registers.
  bvs_pkg::cmd_t        cmd_r, cmd_nxt;
  bvs_pkg::out_item_t   res_r, res_nxt;
  bvs_pkg::out_item_t   out_data_r, out_data_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [CELL_AW-1:0]   cell_r, cell_nxt;
  logic [15:0]          cnt_r, cnt_nxt;
  logic [7:0]           pix_q_r;

  // Memory port controls.
  logic                 char_we, attr_we, pix_we, pix_re;
  logic [CELL_AW-1:0]   text_addr;
  logic [7:0]           char_wdata, attr_wdata, pix_wdata;
  logic [PIX_AW-1:0]    pix_addr;

  // Shared conditions.
  logic                 out_free, fill_done, clr_done, start_fill, is_set_mode;

  assign out_free    = !out_valid_r || !out_stall;
  assign fill_done   = (cnt_r == 16'd1) || (cell_r == CELL_LAST);
  assign clr_done    = (clr_addr_r == CLR_LAST);
  assign is_set_mode = (cmd_r.op == bvs_pkg::OP_SET_MODE);
  assign start_fill  = (cmd_r.op == bvs_pkg::OP_WRITE_CHAR) &&
                       (mode_r == bvs_pkg::MODE_TEXT) && (cmd_r.item.cx != 16'd0);
  assign q_pop       = (state_r == bvs_pkg::ST_IDLE) && q_valid;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bvs_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = clr_resp_r ? bvs_pkg::ST_FINISH : bvs_pkg::ST_IDLE;
        end
      end
      bvs_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = bvs_pkg::ST_EXEC;
        end
      end
      bvs_pkg::ST_EXEC: begin
        if (is_set_mode) begin
          state_nxt = bvs_pkg::ST_CLEAR;
        end else if (start_fill) begin
          state_nxt = bvs_pkg::ST_FILL;
        end else begin
          state_nxt = bvs_pkg::ST_FINISH;
        end
      end
      bvs_pkg::ST_FILL: begin
        if (fill_done) begin
          state_nxt = bvs_pkg::ST_FINISH;
        end
      end
      bvs_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = bvs_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Datapath and memory controls for each state.
  always_comb begin
    mode_nxt      = mode_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    clr_addr_nxt  = clr_addr_r;
    clr_resp_nxt  = clr_resp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    rd_pend_nxt   = rd_pend_r;
    cell_nxt      = cell_r;
    cnt_nxt       = cnt_r;
    char_we       = 1'b0;
    attr_we       = 1'b0;
    pix_we        = 1'b0;
    pix_re        = 1'b0;
    text_addr     = cell_r;
    char_wdata    = '0;
    attr_wdata    = '0;
    pix_wdata     = '0;
    pix_addr      = cmd_r.pix_addr[PIX_AW-1:0];

    unique case (state_r)
      // Sweep both buffers to zero, one entry of each per cycle.
      bvs_pkg::ST_CLEAR: begin
        char_we      = (clr_addr_r < CELL_END);
        attr_we      = (clr_addr_r < CELL_END);
        text_addr    = clr_addr_r[CELL_AW-1:0];
        pix_we       = (clr_addr_r < PIX_END);
        pix_addr     = clr_addr_r[PIX_AW-1:0];
        clr_addr_nxt = clr_done ? '0 : clr_addr_r + CLR_W'(1);
      end
      bvs_pkg::ST_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_data;
        end
      end
      // Carry out the call; registers come back unchanged unless noted.
      bvs_pkg::ST_EXEC: begin
        res_nxt.status = bvs_pkg::STAT_OK;
        res_nxt.out_ax = {cmd_r.item.function_req, cmd_r.item.al};
        res_nxt.out_bx = cmd_r.item.bx;
        res_nxt.out_cx = cmd_r.item.cx;
        res_nxt.out_dx = cmd_r.item.dx;
        rd_pend_nxt    = 1'b0;
        unique case (cmd_r.op)
          bvs_pkg::OP_SET_MODE: begin
            mode_nxt     = cmd_r.item.al;
            row_nxt      = '0;
            col_nxt      = '0;
            clr_addr_nxt = '0;
            clr_resp_nxt = 1'b1;
          end
          bvs_pkg::OP_SET_CURSOR: begin
            row_nxt = (cmd_r.item.dx[15:8] > ROW_MAX) ? ROW_MAX : cmd_r.item.dx[15:8];
            col_nxt = (cmd_r.item.dx[7:0] > COL_MAX) ? COL_MAX : cmd_r.item.dx[7:0];
          end
          bvs_pkg::OP_GET_CURSOR: begin
            res_nxt.out_dx = {row_r, col_r};
            res_nxt.out_cx = bvs_pkg::CURSOR_SHAPE;
          end
          bvs_pkg::OP_WRITE_CHAR: begin
            if (mode_r != bvs_pkg::MODE_TEXT) begin
              res_nxt.status = bvs_pkg::STAT_UNSUP;
            end
            cell_nxt = CELL_AW'(row_r) * COLS_W + CELL_AW'(col_r);
            cnt_nxt  = cmd_r.item.cx;
          end
          bvs_pkg::OP_WRITE_PIXEL, bvs_pkg::OP_READ_PIXEL: begin
            if (mode_r != bvs_pkg::MODE_GFX) begin
              res_nxt.status = bvs_pkg::STAT_UNSUP;
            end else if (!cmd_r.pix_ok) begin
              res_nxt.status = bvs_pkg::STAT_FAULT;
            end else if (cmd_r.op == bvs_pkg::OP_WRITE_PIXEL) begin
              pix_we    = 1'b1;
              pix_wdata = cmd_r.item.al;
            end else begin
              pix_re      = 1'b1;
              rd_pend_nxt = 1'b1;
            end
          end
          bvs_pkg::OP_TELETYPE: begin
            res_nxt.status = bvs_pkg::STAT_TTY;
          end
          bvs_pkg::OP_GET_MODE: begin
            res_nxt.out_ax = {(mode_r == bvs_pkg::MODE_TEXT) ? TEXT_COLS_B : GFX_COLS_B,
                              mode_r};
            res_nxt.out_bx = cmd_r.item.bx & bvs_pkg::LOW_BYTE_MASK;
          end
          bvs_pkg::OP_UNSUPPORTED: begin
            res_nxt.status = bvs_pkg::STAT_UNSUP;
          end
          default: begin
            res_nxt.status = bvs_pkg::STAT_UNSUP;
          end
        endcase
      end
      // Repeated character write, one cell per cycle from the cursor.
      bvs_pkg::ST_FILL: begin
        char_we    = 1'b1;
        char_wdata = cmd_r.item.al;
        attr_we    = cmd_r.wr_attr;
        attr_wdata = cmd_r.item.bx[7:0];
        text_addr  = cell_r;
        cell_nxt   = cell_r + CELL_AW'(1);
        cnt_nxt    = cnt_r - 16'd1;
      end
      // Hand the result to the output register once it is free.
      bvs_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          if (rd_pend_r) begin
            out_data_nxt.out_ax[7:0] = pix_q_r;
          end
          clr_resp_nxt = 1'b0;
        end
      end
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bvs_pkg::ST_CLEAR;
      mode_r      <= bvs_pkg::MODE_TEXT;
      row_r       <= '0;
      col_r       <= '0;
      clr_addr_r  <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    res_r      <= res_nxt;
    rd_pend_r  <= rd_pend_nxt;
    cell_r     <= cell_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Text cell and pixel memories with a registered pixel read.
  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[text_addr] <= char_wdata;
    end
    if (attr_we) begin
      attr_mem[text_addr] <= attr_wdata;
    end
    if (pix_we) begin
      pix_mem[pix_addr] <= pix_wdata;
    end
    if (pix_re) begin
      pix_q_r <= pix_mem[pix_addr];
    end
  end

  // The fill counter never runs past its last cell.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bvs_pkg::ST_FILL |-> cnt_r != 16'd0)
    else $error("fill counter reached zero while filling");

  // Fill addresses stay inside the text screen.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bvs_pkg::ST_FILL |-> cell_r <= CELL_LAST)
    else $error("fill address beyond the last text cell");

  // Only the two supported modes can ever be stored.
  assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == bvs_pkg::MODE_TEXT || mode_r == bvs_pkg::MODE_GFX)
    else $error("video mode register holds an unsupported mode");

  // The cursor is always clamped to the screen.
  assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_MAX && col_r <= COL_MAX)
    else $error("cursor outside the text screen");

  // A finished read pixel leaves with the data that the memory returned.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bvs_pkg::ST_FINISH && out_free && rd_pend_r
      |=> out_valid_r && out_data_r.out_ax[7:0] == $past(pix_q_r))
    else $error("read pixel result lost its data");

endmodule

// File: sv/bios_video_service.sv
// ----------------------------------------------------------------------------
// bios_video_service: video service call unit
// Executes text and graphics video service calls against an on-chip text
// screen and pixel buffer, one result transaction per call transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Calls enter on in_valid/in_stall/in_data (AH, AL, BX, CX, DX); each call
//   returns exactly one result on out_valid/out_stall/out_data with a status
//   and the registers after the call, in call order.
//   A call is decoded in the front end, waits in a two-entry command queue and
//   is executed by the back end. The back end runs each call through its idle,
//   execute and finish states and takes the next call only after finishing.
//   A character write adds one fill step per cell written, up to the cell count
//   (2000 at the default geometry). A valid set mode adds a clearing sweep over
//   max(text cells, pixels) entries (64000 at the default geometry).
//   After reset the same clearing sweep runs once; the front end and queue
//   still take three calls, then in_stall rises until the sweep ends.
//   When the receiver stalls, the result is held in the output register, the
//   back end waits, and in_stall rises once the queue and decoder are full.
// ----------------------------------------------------------------------------
module bios_video_service #(
  parameter int TEXT_COLUMNS = bvs_pkg::DEF_TEXT_COLUMNS,
  parameter int TEXT_ROWS    = bvs_pkg::DEF_TEXT_ROWS,
  parameter int GFX_WIDTH    = bvs_pkg::DEF_GFX_WIDTH,
  parameter int GFX_HEIGHT   = bvs_pkg::DEF_GFX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bvs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bvs_pkg::out_item_t out_data
);

  logic          q_push, q_full, q_valid, q_pop;
  bvs_pkg::cmd_t q_push_data, q_data;

  // Decoder.
  bvs_front #(
    .GFX_WIDTH  (GFX_WIDTH),
    .GFX_HEIGHT (GFX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_push_data)
  );

  // Command queue.
  bvs_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // Execution unit.
  bvs_back #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .GFX_WIDTH    (GFX_WIDTH),
    .GFX_HEIGHT   (GFX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: bench/bios_video_service_tb.sv
// ----------------------------------------------------------------------------
// bios_video_service_tb: self-checking bench for the video service call unit
// A short table of hand-picked calls runs first: register extremes, every
// service code, wrong-mode calls, a bad mode number, cursor clamping, pixel
// bounds and an unknown code. Several random phases follow, each one opened by
// a mode change. Every accepted call is run through a local model of the
// service state, and each returned transaction is checked field by field.
// ----------------------------------------------------------------------------
module bios_video_service_tb;

  localparam int TXT_COLS = bvs_pkg::DEF_TEXT_COLUMNS;
  localparam int TXT_ROWS = bvs_pkg::DEF_TEXT_ROWS;
  localparam int GFX_W    = bvs_pkg::DEF_GFX_WIDTH;
  localparam int GFX_H    = bvs_pkg::DEF_GFX_HEIGHT;
  localparam int CELLS    = TXT_COLS * TXT_ROWS;
  localparam int PIXELS   = GFX_W * GFX_H;

  localparam int PHASES         = 6;
  localparam int PHASE_CALLS    = 50;
  localparam int DRAIN_CYCLES   = 50;
  localparam int LIMIT_CYCLES   = 5_000_000;

  typedef struct {
    bvs_pkg::in_item_t  call;
    bit                 typed;
    bvs_pkg::out_item_t want;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bvs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bvs_pkg::out_item_t out_data;

  // Shadow of the service state, updated once per accepted call.
  logic [7:0]  shadow_mode = bvs_pkg::MODE_TEXT;
  logic [7:0]  shadow_row = '0;
  logic [7:0]  shadow_col = '0;
  bit   [15:0] screen_cells [CELLS];
  bit   [7:0]  pixel_mem [PIXELS];

  bvs_pkg::out_item_t pending_results [$];
  directed_row_t      directed_rows [$];
  bit                 idle_on = 1'b1;
  int                 errors = 0;
  int                 cycle_count = 0;

  bios_video_service dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Predicts the registers and status after one call and applies its effects.
  function automatic bvs_pkg::out_item_t service_call_result(bvs_pkg::in_item_t c);
    bvs_pkg::out_item_t r;
    int unsigned        pos;
    int unsigned        n;
    int unsigned        row;
    int unsigned        col;
    logic [7:0]         cols;
    r.status = bvs_pkg::STAT_OK;
    r.out_ax = {c.function_req, c.al};
    r.out_bx = c.bx;
    r.out_cx = c.cx;
    r.out_dx = c.dx;
    case (c.function_req)
      bvs_pkg::FN_SET_MODE: begin
        if (c.al != bvs_pkg::MODE_TEXT && c.al != bvs_pkg::MODE_GFX) begin
          r.status = bvs_pkg::STAT_UNSUP;
        end else begin
          shadow_mode = c.al;
          shadow_row = '0;
          shadow_col = '0;
          foreach (screen_cells[i]) screen_cells[i] = '0;
          foreach (pixel_mem[i]) pixel_mem[i] = '0;
        end
      end
      bvs_pkg::FN_SET_CURSOR: begin
        row = 32'(c.dx[15:8]);
        col = 32'(c.dx[7:0]);
        if (row >= TXT_ROWS) row = TXT_ROWS - 1;
        if (col >= TXT_COLS) col = TXT_COLS - 1;
        shadow_row = 8'(row);
        shadow_col = 8'(col);
      end
      bvs_pkg::FN_GET_CURSOR: begin
        r.out_dx = {shadow_row, shadow_col};
        r.out_cx = bvs_pkg::CURSOR_SHAPE;
      end
      bvs_pkg::FN_WRITE_CHAR_ATTR, bvs_pkg::FN_WRITE_CHAR: begin
        if (shadow_mode != bvs_pkg::MODE_TEXT) begin
          r.status = bvs_pkg::STAT_UNSUP;
        end else begin
          // Fill from the cursor cell; the cursor itself stays put.
          pos = shadow_row * TXT_COLS + shadow_col;
          for (n = 0; n < c.cx && pos < CELLS; n++) begin
            screen_cells[pos] = {(c.function_req == bvs_pkg::FN_WRITE_CHAR_ATTR) ?
                                 c.bx[7:0] : screen_cells[pos][15:8], c.al};
            pos++;
          end
        end
      end
      bvs_pkg::FN_WRITE_PIXEL, bvs_pkg::FN_READ_PIXEL: begin
        if (shadow_mode != bvs_pkg::MODE_GFX) begin
          r.status = bvs_pkg::STAT_UNSUP;
        end else if (c.cx >= GFX_W || c.dx >= GFX_H) begin
          r.status = bvs_pkg::STAT_FAULT;
        end else begin
          pos = c.dx * GFX_W + c.cx;
          if (c.function_req == bvs_pkg::FN_WRITE_PIXEL) pixel_mem[pos] = c.al;
          else r.out_ax[7:0] = pixel_mem[pos];
        end
      end
      bvs_pkg::FN_TELETYPE: begin
        r.status = bvs_pkg::STAT_TTY;
      end
      bvs_pkg::FN_GET_MODE: begin
        cols = 8'((shadow_mode == bvs_pkg::MODE_TEXT) ? TXT_COLS : GFX_W / 8);
        r.out_ax = {cols, shadow_mode};
        r.out_bx = c.bx & bvs_pkg::LOW_BYTE_MASK;
      end
      default: begin
        r.status = bvs_pkg::STAT_UNSUP;
      end
    endcase
    return r;
  endfunction

  function automatic bvs_pkg::in_item_t call_of(logic [7:0] fn, logic [7:0] al,
                                                logic [15:0] bx, logic [15:0] cx,
                                                logic [15:0] dx);
    bvs_pkg::in_item_t c;
    c.function_req = fn;
    c.al = al;
    c.bx = bx;
    c.cx = cx;
    c.dx = dx;
    return c;
  endfunction

  function automatic bvs_pkg::out_item_t reply_of(bvs_pkg::status_t st, logic [15:0] ax,
                                                  logic [15:0] bx, logic [15:0] cx,
                                                  logic [15:0] dx);
    bvs_pkg::out_item_t r;
    r.status = st;
    r.out_ax = ax;
    r.out_bx = bx;
    r.out_cx = cx;
    r.out_dx = dx;
    return r;
  endfunction

  function automatic void add_row(bvs_pkg::in_item_t c, bit typed = 1'b0,
                                  bvs_pkg::out_item_t want = '0);
    directed_row_t row;
    row.call = c;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // One random call, shaped for the mode the current phase has set up.
  function automatic bvs_pkg::in_item_t random_call(bit gfx);
    bvs_pkg::in_item_t c;
    int unsigned       pick;
    c = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // Raw noise; a valid mode change would cost a full clearing sweep.
      if (c.function_req == bvs_pkg::FN_SET_MODE &&
          (c.al == bvs_pkg::MODE_TEXT || c.al == bvs_pkg::MODE_GFX))
        c.al[7] = 1'b1;
    end else if (pick < 12) begin
      c.function_req = bvs_pkg::FN_SET_MODE;
      if (c.al == bvs_pkg::MODE_TEXT || c.al == bvs_pkg::MODE_GFX) c.al[7] = 1'b1;
    end else if (pick < 16) begin
      c.function_req = bvs_pkg::FN_TELETYPE;
    end else if (pick < 20) begin
      c.function_req = bvs_pkg::FN_GET_MODE;
    end else if (pick < 24) begin
      // Calls that the current mode refuses.
      if (gfx) begin
        c.function_req = pick[0] ? bvs_pkg::FN_WRITE_CHAR_ATTR : bvs_pkg::FN_WRITE_CHAR;
      end else begin
        c.function_req = pick[0] ? bvs_pkg::FN_WRITE_PIXEL : bvs_pkg::FN_READ_PIXEL;
      end
    end else if (pick < 34) begin
      c.function_req = bvs_pkg::FN_SET_CURSOR;
      if ($urandom_range(0, 2) != 0) begin
        c.dx[15:8] = 8'($urandom_range(0, TXT_ROWS - 1));
        c.dx[7:0] = 8'($urandom_range(0, TXT_COLS - 1));
      end
    end else if (pick < 40) begin
      c.function_req = bvs_pkg::FN_GET_CURSOR;
    end else if (gfx) begin
      c.function_req = pick[0] ? bvs_pkg::FN_WRITE_PIXEL : bvs_pkg::FN_READ_PIXEL;
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          c.cx = 16'($urandom_range(GFX_W - 2, GFX_W));
          c.dx = 16'($urandom_range(GFX_H - 2, GFX_H));
        end
        default: begin
          // A small window, so that reads land on written pixels.
          c.cx = 16'($urandom_range(0, 15));
          c.dx = 16'($urandom_range(0, 15));
        end
      endcase
    end else begin
      c.function_req = pick[0] ? bvs_pkg::FN_WRITE_CHAR_ATTR : bvs_pkg::FN_WRITE_CHAR;
      if ($urandom_range(0, 9) != 0) c.cx = 16'($urandom_range(0, 40));
    end
    return c;
  endfunction

  // Offers one call transaction, with an optional idle burst before it.
  task automatic send_call(bvs_pkg::in_item_t c, bit typed, bvs_pkg::out_item_t want);
    bvs_pkg::out_item_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    predicted = service_call_result(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Holds the sender back until every outstanding result has returned.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver stalls in random bursts.
  always begin
    @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 13)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [15:0] want,
                                      logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compares each returned transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    bvs_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("out_ax", want.out_ax, out_data.out_ax);
        check_field("out_bx", want.out_bx, out_data.out_bx);
        check_field("out_cx", want.out_cx, out_data.out_cx);
        check_field("out_dx", want.out_dx, out_data.out_dx);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases, then the drain.
  initial begin
    // Text mode right after reset.
    add_row(call_of(bvs_pkg::FN_GET_MODE, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
            reply_of(bvs_pkg::STAT_OK, 16'h5003, 16'h00FF, 16'hFFFF, 16'hFFFF));
    add_row(call_of(bvs_pkg::FN_GET_CURSOR, 8'hFF, 16'h0000, 16'h0000, 16'hFFFF), 1'b1,
            reply_of(bvs_pkg::STAT_OK, 16'h03FF, 16'h0000, bvs_pkg::CURSOR_SHAPE,
                     16'h0000));
    // Cursor past both limits clamps to the last row and column.
    add_row(call_of(bvs_pkg::FN_SET_CURSOR, 8'h00, 16'h0000, 16'h0000, 16'hFFFF));
    add_row(call_of(bvs_pkg::FN_GET_CURSOR, 8'h00, 16'h1234, 16'h0000, 16'h0000), 1'b1,
            reply_of(bvs_pkg::STAT_OK, 16'h0300, 16'h1234, bvs_pkg::CURSOR_SHAPE,
                     16'h184F));
    // A huge count stops at the last cell of the screen.
    add_row(call_of(bvs_pkg::FN_WRITE_CHAR_ATTR, 8'h41, 16'h0017, 16'hFFFF, 16'h0000));
    add_row(call_of(bvs_pkg::FN_SET_CURSOR, 8'h00, 16'h0000, 16'h0000, 16'h0000));
    add_row(call_of(bvs_pkg::FN_WRITE_CHAR_ATTR, 8'hFF, 16'hFF80, 16'h0003, 16'h0000));
    add_row(call_of(bvs_pkg::FN_WRITE_CHAR, 8'h00, 16'h0000, 16'h0000, 16'h0000));
    add_row(call_of(bvs_pkg::FN_WRITE_CHAR, 8'h5A, 16'hFFFF, 16'h0005, 16'hFFFF));
    add_row(call_of(bvs_pkg::FN_SET_CURSOR, 8'h00, 16'h0000, 16'h0000, 16'h1800));
    add_row(call_of(bvs_pkg::FN_WRITE_CHAR, 8'h78, 16'h0000, 16'h8000, 16'h0000));
    // Pixel calls are refused in text mode.
    add_row(call_of(bvs_pkg::FN_WRITE_PIXEL, 8'h07, 16'h0001, 16'h0002, 16'h0003), 1'b1,
            reply_of(bvs_pkg::STAT_UNSUP, 16'h0C07, 16'h0001, 16'h0002, 16'h0003));
    add_row(call_of(bvs_pkg::FN_READ_PIXEL, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b1,
            reply_of(bvs_pkg::STAT_UNSUP, 16'h0D00, 16'h0000, 16'h0000, 16'h0000));
    add_row(call_of(bvs_pkg::FN_TELETYPE, 8'h41, 16'h0007, 16'h0001, 16'h0000), 1'b1,
            reply_of(bvs_pkg::STAT_TTY, 16'h0E41, 16'h0007, 16'h0001, 16'h0000));
    add_row(call_of(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
            reply_of(bvs_pkg::STAT_UNSUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_row(call_of(bvs_pkg::FN_SET_MODE, 8'h12, 16'h0000, 16'h0000, 16'h0000), 1'b1,
            reply_of(bvs_pkg::STAT_UNSUP, 16'h0012, 16'h0000, 16'h0000, 16'h0000));
    // Graphics mode.
    add_row(call_of(bvs_pkg::FN_SET_MODE, bvs_pkg::MODE_GFX, 16'hFFFF, 16'hFFFF,
                    16'hFFFF), 1'b1,
            reply_of(bvs_pkg::STAT_OK, 16'h0013, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_row(call_of(bvs_pkg::FN_GET_MODE, 8'h00, 16'hA5C3, 16'h0000, 16'h0000), 1'b1,
            reply_of(bvs_pkg::STAT_OK, 16'h2813, 16'h00C3, 16'h0000, 16'h0000));
    add_row(call_of(bvs_pkg::FN_GET_CURSOR, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b1,
            reply_of(bvs_pkg::STAT_OK, 16'h0300, 16'h0000, bvs_pkg::CURSOR_SHAPE,
                     16'h0000));
    add_row(call_of(bvs_pkg::FN_WRITE_CHAR_ATTR, 8'h41, 16'h0007, 16'h000A, 16'h0000),
            1'b1,
            reply_of(bvs_pkg::STAT_UNSUP, 16'h0941, 16'h0007, 16'h000A, 16'h0000));
    add_row(call_of(bvs_pkg::FN_WRITE_PIXEL, 8'hFF, 16'h0000, 16'h013F, 16'h00C7));
    add_row(call_of(bvs_pkg::FN_READ_PIXEL, 8'h00, 16'h0000, 16'h013F, 16'h00C7), 1'b1,
            reply_of(bvs_pkg::STAT_OK, 16'h0DFF, 16'h0000, 16'h013F, 16'h00C7));
    // Coordinates one past either edge fault.
    add_row(call_of(bvs_pkg::FN_WRITE_PIXEL, 8'h55, 16'h0000, 16'h0140, 16'h0000), 1'b1,
            reply_of(bvs_pkg::STAT_FAULT, 16'h0C55, 16'h0000, 16'h0140, 16'h0000));
    add_row(call_of(bvs_pkg::FN_READ_PIXEL, 8'h00, 16'h0000, 16'h0000, 16'h00C8), 1'b1,
            reply_of(bvs_pkg::STAT_FAULT, 16'h0D00, 16'h0000, 16'h0000, 16'h00C8));
    add_row(call_of(bvs_pkg::FN_WRITE_PIXEL, 8'h81, 16'h0000, 16'h0000, 16'h0000));
    add_row(call_of(bvs_pkg::FN_READ_PIXEL, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b1,
            reply_of(bvs_pkg::STAT_OK, 16'h0D81, 16'h0000, 16'h0000, 16'h0000));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_call(directed_rows[i].call, directed_rows[i].typed, directed_rows[i].want);

    // Each phase drains the block, switches mode and runs random calls.
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase != 2) && (phase != PHASES - 1);
      wait_for_idle();
      send_call(call_of(bvs_pkg::FN_SET_MODE,
                        (phase % 2 == 0) ? bvs_pkg::MODE_TEXT : bvs_pkg::MODE_GFX,
                        16'($urandom), 16'($urandom), 16'($urandom)), 1'b0, '0);
      for (int k = 1; k < PHASE_CALLS; k++)
        send_call(random_call(phase % 2 == 1), 1'b0, '0);
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
